@@ src/fd_pkg.sv @@
package fd_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned DECIM_W = 8;
  localparam int unsigned TAPS_W  = 7;

  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_DECIM = 1'b0;
  localparam logic REG_TAPS  = 1'b1;

  typedef enum logic [1:0] {
    KIND_COEF,
    KIND_SAMPLE,
    KIND_OUTPUT
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic [IDX_W-1:0]          coef_index;
    logic signed [DATA_W-1:0]  value;
  } fd_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fd_qstat_t;

endpackage

@@ src/fd_ram.sv @@
module fd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fd_queue.sv @@
module fd_queue import fd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  fd_cmd_t   push_data_i,
  input  logic      pop_i,
  output fd_cmd_t   head_o,
  output fd_qstat_t stat_o
);

  fd_cmd_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/fd_front.sv @@
module fd_front import fd_pkg::*; #(
  parameter int unsigned MAX_TAPS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     command_i,
  input  logic [IDX_W-1:0]         coef_index_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [DECIM_W-1:0]       decim_factor_i,
  input  logic                     clear_done_i,
  input  fd_qstat_t                qstat_i,
  output logic                     push_o,
  output fd_cmd_t                  push_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam int unsigned MOD_STEPS = DECIM_W + 1;
  localparam int unsigned STEP_W    = $clog2(MOD_STEPS + 1);

  logic [1:0]            state_q, state_d;
  logic [DECIM_W-1:0]    cnt_q, cnt_d;
  logic [DECIM_W-1:0]    div_q, div_d;
  logic [DECIM_W:0]      num_q, num_d;
  logic [DECIM_W:0]      rem_q, rem_d;
  logic [STEP_W-1:0]     step_q, step_d;
  fd_cmd_t               item_q, item_d;

  logic                  accept;
  logic [DECIM_W-1:0]    d_eff;
  logic [DECIM_W-1:0]    cnt_dec;
  logic [DECIM_W:0]      rem_shift;
  logic                  idx_ok;

  assign in_ready_o = (state_q == ST_IDLE) && clear_done_i && !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign d_eff      = (decim_factor_i == '0) ? DECIM_W'(1) : decim_factor_i;
  assign cnt_dec    = cnt_q - DECIM_W'(1);
  assign rem_shift  = {rem_q[DECIM_W-1:0], num_q[DECIM_W]};
  assign idx_ok     = (32'(coef_index_i) < MAX_TAPS);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    div_d       = div_q;
    num_d       = num_q;
    rem_d       = rem_q;
    step_d      = step_q;
    item_d      = item_q;
    push_o      = 1'b0;
    push_data_o = '{kind: KIND_SAMPLE, coef_index: coef_index_i, value: value_i};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_COEF) begin
            push_data_o.kind = KIND_COEF;
            push_o           = idx_ok;
          end else if (cnt_q <= d_eff) begin
            // count within factor: modular update is a plain decrement
            push_o = 1'b1;
            if (cnt_dec == '0) begin
              push_data_o.kind = KIND_OUTPUT;
              cnt_d            = d_eff;
            end else begin
              cnt_d = cnt_dec;
            end
          end else begin
            item_d  = push_data_o;
            div_d   = d_eff;
            num_d   = {1'b0, cnt_q} + {1'b0, d_eff} - (DECIM_W+1)'(1);
            rem_d   = '0;
            step_d  = STEP_W'(MOD_STEPS);
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        // restoring remainder, one bit per cycle
        rem_d  = (rem_shift >= {1'b0, div_q}) ? rem_shift - {1'b0, div_q} : rem_shift;
        num_d  = {num_q[DECIM_W-1:0], 1'b0};
        step_d = step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        push_data_o      = item_q;
        push_data_o.kind = (rem_q == '0) ? KIND_OUTPUT : KIND_SAMPLE;
        if (!qstat_i.full) begin
          push_o  = 1'b1;
          cnt_d   = (rem_q == '0) ? div_q : rem_q[DECIM_W-1:0];
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= DECIM_W'(1);
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    item_q <= item_d;
  end

endmodule

@@ src/fd_back.sv @@
module fd_back import fd_pkg::*; #(
  parameter int unsigned MAX_TAPS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [TAPS_W-1:0]        tap_count_i,
  input  fd_cmd_t                  head_i,
  input  fd_qstat_t                qstat_i,
  output logic                     pop_o,
  output logic                     clear_done_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] out_sample_o,
  output logic                     out_ovf_o
);

  localparam int unsigned AW    = $clog2(MAX_TAPS);
  localparam int unsigned TW    = $clog2(MAX_TAPS + 1);
  localparam int unsigned ACC_W = 2 * DATA_W + $clog2(MAX_TAPS);
  localparam logic [AW-1:0] LAST = AW'(MAX_TAPS - 1);
  localparam logic signed [ACC_W:0] RND     = (ACC_W+1)'(1) << (DATA_W - 2);
  localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W+1)'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_MIN = ~SAT_MAX;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_MAC   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic [AW-1:0]              clr_q, clr_d;
  logic [AW-1:0]              pos_q, pos_d;
  logic [AW-1:0]              mpos_q, mpos_d;
  logic [TW-1:0]              n_q, n_d;
  logic                       rd_vld_q, prod_vld_q;
  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic                       out_vld_q, out_vld_d;
  logic signed [DATA_W-1:0]   out_sample_q;
  logic                       out_ovf_q;

  logic [TW-1:0]              taps_eff;
  logic [AW-1:0]              pos_dec, mpos_inc;
  logic                       issue, load_out, clearing;
  logic                       coef_we, dly_we;
  logic [AW-1:0]              coef_waddr, dly_waddr;
  logic [DATA_W-1:0]          coef_wdata, dly_wdata;
  logic [DATA_W-1:0]          coef_rd, dly_rd;
  logic signed [ACC_W:0]      rnd_sum, rnd_y;
  logic                       sat_hi, sat_lo;

  assign taps_eff = (32'(tap_count_i) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(tap_count_i);
  assign pos_dec  = (pos_q == '0) ? LAST : pos_q - AW'(1);
  assign mpos_inc = (mpos_q == LAST) ? '0 : mpos_q + AW'(1);
  assign clearing = (state_q == ST_CLEAR);
  assign pop_o    = (state_q == ST_IDLE) && !qstat_i.empty;
  assign issue    = (state_q == ST_MAC) && (n_q < taps_eff);
  assign clear_done_o = !clearing;

  assign coef_we    = clearing || (pop_o && head_i.kind == KIND_COEF);
  assign coef_waddr = clearing ? clr_q : AW'(head_i.coef_index);
  assign coef_wdata = clearing ? '0 : head_i.value;
  assign dly_we     = clearing || (pop_o && (head_i.kind == KIND_SAMPLE ||
                                             head_i.kind == KIND_OUTPUT));
  assign dly_waddr  = clearing ? clr_q : pos_dec;
  assign dly_wdata  = clearing ? '0 : head_i.value;

  fd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (n_q[AW-1:0]),
    .rdata_o (coef_rd)
  );

  fd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (dly_wdata),
    .raddr_i (mpos_q),
    .rdata_o (dly_rd)
  );

  // round half up, floor shift, saturate
  assign rnd_sum = {acc_q[ACC_W-1], acc_q} + RND;
  assign rnd_y   = rnd_sum >>> (DATA_W - 1);
  assign sat_hi  = (rnd_y > SAT_MAX);
  assign sat_lo  = (rnd_y < SAT_MIN);

  assign load_out = (state_q == ST_DRAIN) && !rd_vld_q && !prod_vld_q &&
                    (!out_vld_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    pos_d     = pos_q;
    mpos_d    = mpos_q;
    n_d       = n_q;
    acc_d     = prod_vld_q ? acc_q + ACC_W'(prod_q) : acc_q;
    out_vld_d = out_vld_q && !out_ready_i;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_o && (head_i.kind == KIND_SAMPLE || head_i.kind == KIND_OUTPUT)) begin
          pos_d = pos_dec;
        end
        if (pop_o && head_i.kind == KIND_OUTPUT) begin
          mpos_d  = pos_dec;
          n_d     = '0;
          acc_d   = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (issue) begin
          n_d    = n_q + TW'(1);
          mpos_d = mpos_inc;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      pos_q      <= '0;
      n_q        <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      pos_q      <= pos_d;
      n_q        <= n_d;
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mpos_q <= mpos_d;
    acc_q  <= acc_d;
    prod_q <= $signed(coef_rd) * $signed(dly_rd);
    if (load_out) begin
      out_sample_q <= sat_hi ? SAT_MAX[DATA_W-1:0] :
                      sat_lo ? SAT_MIN[DATA_W-1:0] : rnd_y[DATA_W-1:0];
      out_ovf_q    <= sat_hi || sat_lo;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_sample_o = out_sample_q;
  assign out_ovf_o    = out_ovf_q;

endmodule

@@ src/fir_decimator.sv @@
// Channel  Dir  Fields (lowest bit first)                  Handshake
// s_axis   in   tuser: command; tdata: coef_index, value   tvalid/tready
// m_axis   out  tuser: overflow; tdata: filtered_sample    tvalid/tready
// cfg      in   cfg_addr_i 0: decim_factor, 1: tap_count  cfg_we_i, no wait
//
// After reset a clearing pass zeroes both tap memories;
// s_axis_tready stays low meanwhile.
// In the back end each output sample takes one shared multiply-accumulate per tap
// (min(tap_count, MAX_TAPS) taps), read from the two tap RAMs.
// Coefficient writes and non-output samples need no multiply-accumulate.
// A sample arriving while the decimation count exceeds decim_factor passes
// through a bit-serial remainder (ST_MOD, then ST_PUSH) in the front end.
// A 2-entry queue and the output register let either side stall alone.
module fir_decimator import fd_pkg::*; #(
  parameter int unsigned MAX_TAPS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [DECIM_W-1:0] cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // coef_index[5:0], value[21:6], zero pad
  input  logic [0:0]         s_axis_tuser,   // command[0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // filtered_sample[15:0]
  output logic [0:0]         m_axis_tuser    // overflow[0]
);

  logic [DECIM_W-1:0] decim_q;
  logic [TAPS_W-1:0]  taps_q;
  fd_qstat_t          qstat;
  fd_cmd_t            q_in, q_head;
  logic               q_push, q_pop, clear_done;
  logic signed [DATA_W-1:0] out_sample;
  logic               out_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q <= DECIM_W'(1);
      taps_q  <= TAPS_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_DECIM: decim_q <= cfg_wdata_i;
        REG_TAPS:  taps_q  <= cfg_wdata_i[TAPS_W-1:0];
        default:   decim_q <= decim_q;
      endcase
    end
  end

  fd_front #(.MAX_TAPS(MAX_TAPS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .command_i      (s_axis_tuser[0]),
    .coef_index_i   (s_axis_tdata[5:0]),
    .value_i        ($signed(s_axis_tdata[21:6])),
    .decim_factor_i (decim_q),
    .clear_done_i   (clear_done),
    .qstat_i        (qstat),
    .push_o         (q_push),
    .push_data_o    (q_in)
  );

  fd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (qstat)
  );

  fd_back #(.MAX_TAPS(MAX_TAPS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tap_count_i  (taps_q),
    .head_i       (q_head),
    .qstat_i      (qstat),
    .pop_o        (q_pop),
    .clear_done_o (clear_done),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample),
    .out_ovf_o    (out_ovf)
  );

  assign m_axis_tdata = out_sample;
  assign m_axis_tuser = out_ovf;

  a_no_req_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> clear_done)
    else $error("request taken during clearing pass");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !qstat.full)
    else $error("queue push while full");

  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000))
    else $error("overflow flagged on unsaturated output");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !qstat.empty)
    else $error("queue pop while empty");

endmodule
